// File: rtl/core/bve_pkg.sv
// Package for the bit vector engine: sizes, opcodes, shared structs and the
// nibble population table. Used by every module under rtl/core.
package bve_pkg;

	localparam int MAX_BYTES = 32;
	localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int LIM_W     = 11;

	typedef enum logic [3:0] {
		OP_SET      = 4'd0,
		OP_CLR      = 4'd1,
		OP_TGL      = 4'd2,
		OP_GET      = 4'd3,
		OP_SETALL   = 4'd4,
		OP_CLRALL   = 4'd5,
		OP_TGLALL   = 4'd6,
		OP_ONES     = 4'd7,
		OP_ZEROS    = 4'd8,
		OP_ALLONES  = 4'd9,
		OP_ALLZEROS = 4'd10,
		OP_AND      = 4'd11,
		OP_OR       = 4'd12,
		OP_XOR      = 4'd13,
		OP_COPY     = 4'd14
	} op_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
	} mem_req_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] bit_pos;
		logic [7:0] data;
		logic [7:0] cur;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] nxt;
		logic       wr_en;
		logic [3:0] pop;
		logic       match;
		logic       bit_val;
	} alu_rsp_t;

	typedef struct packed {
		logic       ok;
		logic       bit_value;
		logic [8:0] count;
		logic       test_flag;
	} res_t;

	function automatic logic [2:0] nib_pop(input logic [3:0] v);
		logic [2:0] r;
		case (v)
			4'h0: r = 3'd0;
			4'h1, 4'h2, 4'h4, 4'h8: r = 3'd1;
			4'h3, 4'h5, 4'h6, 4'h9, 4'ha, 4'hc: r = 3'd2;
			4'h7, 4'hb, 4'hd, 4'he: r = 3'd3;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/bit_vector_engine_unit.sv
// Top level of the bit vector engine: configuration port, sequencer, shared
// byte unit, byte store and output register. Uses bve_pkg and rtl/core modules.
//
//  channel  direction  handshake           payload
//  input    in         in_valid/in_stall   opcode, bit_index, byte_index, data_byte
//  output   out        out_valid/out_stall ok, bit_value, count, test_flag
//  config   in         psel/penable/pready paddr, pwdata, prdata (active_bytes at 0)
//
// From acceptance, each walked byte is read from the store and passed through the
// byte unit, and the result then goes to the output register. The bytes walked are
// the active bytes for whole-vector opcodes and one byte for bit and byte opcodes.
// The store's single read port sets the walk to one byte per cycle.
// A new beat is taken once the previous result sits in the output register.
// Reset sets active_bytes to 32 and the store reads as all zeros.
module bit_vector_engine_unit import bve_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [7:0]  bit_index,
	input  logic [4:0]  byte_index,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic        bit_value,
	output logic [8:0]  count,
	output logic        test_flag,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0] active_q;
	mem_req_t   mem_req;
	logic [7:0] mem_rd_data;
	alu_req_t   alu_req;
	alu_rsp_t   alu_rsp;
	logic       res_valid;
	res_t       res;
	logic       res_take;
	logic       out_valid_q;
	res_t       out_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {26'd0, active_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 6'd32;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			active_q <= pwdata[5:0];
		end
	end

	bve_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.active_bytes(active_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.bit_index   (bit_index),
		.byte_index  (byte_index),
		.data_byte   (data_byte),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.alu_req     (alu_req),
		.alu_rsp     (alu_rsp),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take)
	);

	bve_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	bve_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rd_data(mem_rd_data)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = out_q.ok;
	assign bit_value = out_q.bit_value;
	assign count     = out_q.count;
	assign test_flag = out_q.test_flag;

endmodule

// File: rtl/core/bve_store.sv
// Bitmap byte store: one write and one registered read port, with a valid
// bit per entry so that the store reads as zero after reset. Uses bve_pkg.
module bve_store import bve_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rd_data
);

	logic [7:0]           mem_q [MAX_BYTES];
	logic [MAX_BYTES-1:0] vld_q;
	logic [7:0]           rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : 8'h00;

endmodule

// File: rtl/core/bve_alu.sv
// Shared byte unit: next byte value, population count and compare for one
// stored byte under the current opcode. Uses bve_pkg.
module bve_alu import bve_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [7:0] mask;

	assign mask = 8'h01 << req.bit_pos;

	always_comb begin
		rsp.nxt     = req.cur;
		rsp.wr_en   = 1'b0;
		rsp.match   = 1'b0;
		rsp.pop     = {1'b0, nib_pop(req.cur[3:0])} + {1'b0, nib_pop(req.cur[7:4])};
		rsp.bit_val = req.cur[req.bit_pos];
		case (req.op)
			OP_SET: begin
				rsp.nxt   = req.cur | mask;
				rsp.wr_en = 1'b1;
			end
			OP_CLR: begin
				rsp.nxt   = req.cur & ~mask;
				rsp.wr_en = 1'b1;
			end
			OP_TGL: begin
				rsp.nxt   = req.cur ^ mask;
				rsp.wr_en = 1'b1;
			end
			OP_SETALL: begin
				rsp.nxt   = 8'hff;
				rsp.wr_en = 1'b1;
			end
			OP_CLRALL: begin
				rsp.nxt   = 8'h00;
				rsp.wr_en = 1'b1;
			end
			OP_TGLALL: begin
				rsp.nxt   = ~req.cur;
				rsp.wr_en = 1'b1;
			end
			OP_ALLONES: begin
				rsp.match = (req.cur == 8'hff);
			end
			OP_ALLZEROS: begin
				rsp.match = (req.cur == 8'h00);
			end
			OP_AND: begin
				rsp.nxt   = req.cur & req.data;
				rsp.wr_en = 1'b1;
			end
			OP_OR: begin
				rsp.nxt   = req.cur | req.data;
				rsp.wr_en = 1'b1;
			end
			OP_XOR: begin
				rsp.nxt   = req.cur ^ req.data;
				rsp.wr_en = 1'b1;
			end
			OP_COPY: begin
				rsp.nxt   = req.data;
				rsp.wr_en = 1'b1;
			end
			default: begin
				rsp.nxt   = req.cur;
				rsp.wr_en = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/core/bve_ctrl.sv
// Sequencer: takes one beat, walks the selected byte range through the store
// and the shared byte unit, and builds the result. Uses bve_pkg.
module bve_ctrl import bve_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [5:0] active_bytes,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] opcode,
	input  logic [7:0] bit_index,
	input  logic [4:0] byte_index,
	input  logic [7:0] data_byte,
	output mem_req_t   mem_req,
	input  logic [7:0] mem_rd_data,
	output alu_req_t   alu_req,
	input  alu_rsp_t   alu_rsp,
	output logic       res_valid,
	output res_t       res,
	input  logic       res_take
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [2:0]        pos_q;
	logic [7:0]        data_q;
	logic [5:0]        k_q;
	logic [5:0]        end_q;
	logic              pend_q;
	logic [ADDR_W-1:0] ex_addr_q;
	logic              ok_q;
	logic [8:0]        ones_q;
	logic              all_q;
	logic              bit_q;
	logic [8:0]        cap_q;

	logic [5:0] n_used;
	logic [8:0] cap;
	logic       bit_in;
	logic       byte_in;
	logic       accept;
	logic       issue;

	assign n_used  = (LIM_W'(active_bytes) > LIM_W'(MAX_BYTES)) ? 6'(MAX_BYTES) : active_bytes;
	assign cap     = {n_used, 3'b000};
	assign bit_in  = ({1'b0, bit_index} < cap);
	assign byte_in = ({1'b0, byte_index} < n_used);
	assign accept  = in_valid && (state_q == ST_IDLE);
	assign issue   = (state_q == ST_WALK) && (k_q < end_q);
	assign in_stall = (state_q != ST_IDLE);

	assign mem_req.rd_en   = issue;
	assign mem_req.rd_addr = ADDR_W'(k_q);
	assign mem_req.wr_en   = pend_q && alu_rsp.wr_en;
	assign mem_req.wr_addr = ex_addr_q;
	assign mem_req.wr_data = alu_rsp.nxt;

	assign alu_req.op      = op_q;
	assign alu_req.bit_pos = pos_q;
	assign alu_req.data    = data_q;
	assign alu_req.cur     = mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (accept) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					pend_q <= issue;
					if (!issue && !pend_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					pend_q <= 1'b0;
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					pend_q  <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(opcode);
			pos_q  <= bit_index[2:0];
			data_q <= data_byte;
			cap_q  <= cap;
			ones_q <= 9'd0;
			all_q  <= 1'b1;
			bit_q  <= 1'b0;
			ok_q   <= 1'b0;
			k_q    <= 6'd0;
			end_q  <= 6'd0;
			if (opcode <= OP_GET) begin
				ok_q <= bit_in;
				if (bit_in) begin
					k_q   <= {1'b0, bit_index[7:3]};
					end_q <= {1'b0, bit_index[7:3]} + 6'd1;
				end
			end else if (opcode <= OP_ALLZEROS) begin
				ok_q  <= 1'b1;
				end_q <= n_used;
			end else if (opcode <= OP_COPY) begin
				ok_q <= byte_in;
				if (byte_in) begin
					k_q   <= {1'b0, byte_index};
					end_q <= {1'b0, byte_index} + 6'd1;
				end
			end
		end else if (state_q == ST_WALK) begin
			if (issue) begin
				k_q       <= k_q + 6'd1;
				ex_addr_q <= ADDR_W'(k_q);
			end
			if (pend_q) begin
				ones_q <= ones_q + {5'd0, alu_rsp.pop};
				bit_q  <= alu_rsp.bit_val;
				if (!alu_rsp.match) begin
					all_q <= 1'b0;
				end
			end
		end
	end

	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.ok        = ok_q;
		res.bit_value = (op_q == OP_GET) ? bit_q : 1'b0;
		res.count     = 9'd0;
		res.test_flag = 1'b0;
		case (op_q)
			OP_ONES: begin
				res.count = ones_q;
			end
			OP_ZEROS: begin
				res.count = cap_q - ones_q;
			end
			OP_ALLONES, OP_ALLZEROS: begin
				res.test_flag = all_q;
			end
			default: begin
				res.count     = 9'd0;
				res.test_flag = 1'b0;
			end
		endcase
	end

endmodule
